FILE: rtl/ostt_pkg.sv
// shared types and constants of the one-shot timer table
package ostt_pkg;

  localparam int unsigned Slots      = 64;
  localparam int unsigned SlotBits   = $clog2(Slots);
  localparam int unsigned HandleBits = 16;
  localparam int unsigned CmdDepth   = 2;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_CANCEL = 3'd2,
    OP_QUERY  = 3'd3,
    OP_SCAN   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRY  = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_NOTHING = 2'd3
  } kind_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] timer_id;
    logic [31:0] duration;
    logic [31:0] param_token;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] event_id;
    logic [31:0] event_param;
    logic        running;
    logic        last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    opcode_e         op;
    logic            is_valid_op;
    logic [15:0]     handle;
    logic [31:0]     duration;
    logic [31:0]     token;
  } cmd_t;

endpackage

FILE: rtl/ostt_front.sv
// front end: accepts transactions, classifies them and queues commands
module ostt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ostt_pkg::in_item_t in_item_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output ostt_pkg::cmd_t     cmd_o
);
  import ostt_pkg::*;

  cmd_t                        q_mem [CmdDepth];
  logic [$clog2(CmdDepth)-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [$clog2(CmdDepth):0]   cnt_q, cnt_d;
  cmd_t                        cmd_new;
  logic                        do_push, do_pop;

  always_comb begin
    cmd_new.is_valid_op = (in_item_i.opcode <= OP_SCAN);
    cmd_new.op          = opcode_e'(in_item_i.opcode);
    cmd_new.handle      = in_item_i.timer_id & 16'((33'd1 << HandleBits) - 33'd1);
    cmd_new.duration    = in_item_i.duration;
    cmd_new.token       = in_item_i.param_token;
  end

  assign full        = (cnt_q == ($clog2(CmdDepth)+1)'(CmdDepth));
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + ($clog2(CmdDepth)+1)'(do_push) - ($clog2(CmdDepth)+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/ostt_back.sv
// back end: walks the slots one per cycle unless a scan stalls; emits results
module ostt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  ostt_pkg::cmd_t      cmd_i,
  output logic                empty,
  input  logic                pop,
  output ostt_pkg::out_item_t out_item_o
);
  import ostt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q;
  logic [SlotBits:0]   idx_q, idx_d;
  logic [SlotBits-1:0] idx;
  logic [SlotBits-1:0] rd_addr;
  logic                found_q, found_d;
  logic [31:0]         now_q, now_d;
  logic [Slots-1:0]    valid_q, valid_d;

  logic [15:0] mem_handle [Slots];
  logic [31:0] mem_start  [Slots];
  logic [31:0] mem_dur    [Slots];
  logic [31:0] mem_tok    [Slots];

  logic [15:0] rd_handle;
  logic [31:0] rd_start, rd_dur, rd_tok;
  logic [SlotBits-1:0] rd_idx_q;

  // expiry event held back until the next one shows whether it is the last
  logic        pend_q, pend_d;
  logic [15:0] pend_id_q, pend_id_d;
  logic [31:0] pend_tok_q, pend_tok_d;

  out_item_t out_q, out_d;
  logic      out_full_q, out_full_d;
  logic      wr_en;
  logic [SlotBits-1:0] wr_idx;
  logic      ok_cur, match, expired, at_end;
  out_item_t res;
  logic      res_valid;

  assign idx = idx_q[SlotBits-1:0];
  assign rd_addr = (state_q == ST_EMIT && !ok_cur) ? rd_idx_q : idx;
  assign empty = !out_full_q;
  assign out_item_o = out_q;
  assign cmd_ready_o = (state_q == ST_IDLE) && !out_full_q;

  // registered reads of the slot store
  always_ff @(posedge clk_i) begin
    rd_handle <= mem_handle[rd_addr];
    rd_start  <= mem_start[rd_addr];
    rd_dur    <= mem_dur[rd_addr];
    rd_tok    <= mem_tok[rd_addr];
    rd_idx_q  <= rd_addr;
    if (wr_en) begin
      mem_handle[wr_idx] <= cmd_q.handle;
      mem_start[wr_idx]  <= now_q;
      mem_dur[wr_idx]    <= cmd_q.duration;
      mem_tok[wr_idx]    <= cmd_q.token;
    end
  end

  assign match   = valid_q[rd_idx_q] && (rd_handle == cmd_q.handle);
  assign expired = valid_q[rd_idx_q] && ((now_q - rd_start) >= rd_dur);
  assign at_end  = (rd_idx_q == SlotBits'(Slots - 1));
  assign wr_idx  = rd_idx_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    found_d    = found_q;
    now_d      = now_q;
    valid_d    = valid_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    pend_tok_d = pend_tok_q;
    out_d      = out_q;
    out_full_d = out_full_q;
    wr_en      = 1'b0;
    ok_cur     = 1'b0;
    res        = '0;
    res_valid  = 1'b0;
    if (pop && out_full_q) begin
      out_full_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !out_full_q) begin
          idx_d   = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          res.event_id = cmd_i.handle;
          res.last     = 1'b1;
          res.result_kind = KIND_ACK;
          if (!cmd_i.is_valid_op) begin
            res_valid = 1'b1;
          end else if (cmd_i.op == OP_TICK) begin
            now_d     = now_q + 32'd1;
            res_valid = 1'b1;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // first cycle only primes the read
        state_d = ST_EMIT;
        idx_d   = idx_q + 1'b1;
      end
      ST_EMIT: begin
        ok_cur = 1'b1;
        unique case (cmd_q.op)
          OP_START: begin
            if (!found_q) begin
              if (!valid_q[rd_idx_q] || match) begin
                found_d = 1'b1;
                wr_en   = 1'b1;
                valid_d[rd_idx_q] = 1'b1;
              end
            end else if (match) begin
              valid_d[rd_idx_q] = 1'b0;
            end
            if (at_end) begin
              res.result_kind = (found_q || !valid_q[rd_idx_q] || match) ?
                                KIND_ACK : KIND_FULL;
              res.event_id = cmd_q.handle;
              res.last     = 1'b1;
              res_valid    = 1'b1;
            end
          end
          OP_CANCEL: begin
            if (!found_q && match) begin
              found_d = 1'b1;
              valid_d[rd_idx_q] = 1'b0;
            end
            if (at_end) begin
              res.result_kind = KIND_ACK;
              res.event_id = cmd_q.handle;
              res.last     = 1'b1;
              res_valid    = 1'b1;
            end
          end
          OP_QUERY: begin
            if (at_end) begin
              res.result_kind = KIND_ACK;
              res.event_id = cmd_q.handle;
              res.running  = found_q || match;
              res.last     = 1'b1;
              res_valid    = 1'b1;
            end else if (match) begin
              found_d = 1'b1;
            end
          end
          default: begin
            // scan: a new expiry releases the held one, unless it still waits
            if (expired) begin
              if (pend_q && out_full_q && !pop) begin
                ok_cur = 1'b0;
              end else begin
                valid_d[rd_idx_q] = 1'b0;
                pend_d     = 1'b1;
                pend_id_d  = rd_handle;
                pend_tok_d = rd_tok;
                if (pend_q) begin
                  res.result_kind = KIND_EXPIRY;
                  res.event_id    = pend_id_q;
                  res.event_param = pend_tok_q;
                  res_valid       = 1'b1;
                end
              end
            end
          end
        endcase
        if (ok_cur) begin
          if (at_end) begin
            state_d = (cmd_q.op == OP_SCAN) ? ST_FLUSH : ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          idx_d = idx_q;
        end
      end
      ST_FLUSH: begin
        // scan end: final expiry with last, or nothing found
        if (!out_full_q || pop) begin
          res.last = 1'b1;
          if (pend_q) begin
            res.result_kind = KIND_EXPIRY;
            res.event_id    = pend_id_q;
            res.event_param = pend_tok_q;
          end else begin
            res.result_kind = KIND_NOTHING;
          end
          res_valid = 1'b1;
          pend_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (res_valid) begin
      out_d      = res;
      out_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && !out_full_q) begin
      cmd_q <= cmd_i;
    end
    out_q      <= out_d;
    pend_id_q  <= pend_id_d;
    pend_tok_q <= pend_tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      found_q    <= 1'b0;
      now_q      <= '0;
      valid_q    <= '0;
      pend_q     <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= (state_q == ST_EMIT && !ok_cur) ? idx_q : idx_d;
      found_q    <= found_d;
      now_q      <= now_d;
      valid_q    <= valid_d;
      pend_q     <= pend_d;
      out_full_q <= out_full_d;
    end
  end

endmodule

FILE: rtl/one_shot_timer_table.sv
// top level of the one-shot timer table
// A table of 64 one-shot timers keyed by a handle. A tick or an unused opcode
// has its result on the ports in the cycle after the back end takes it; start,
// cancel and query walk the slot table in index order one slot per cycle through
// the registered slot store read port, and a scan ends with a flush state. A scan
// holds each expiry event back until the next one is found, so the final one
// carries last, and stalls while an earlier event waits to be popped. A command
// enters the walk only once the previous result has been popped; commands wait
// in a two-entry queue in front of the walk.
module one_shot_timer_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ostt_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ostt_pkg::out_item_t out_item_o
);
  import ostt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  ostt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ostt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule
